// ===== rtl/bcircle_pkg.sv =====
// Shared types, constants and the pixel-index helper for the circle point generator.
// No dependencies; every other file refers to it by scoped names.
package bcircle_pkg;

   // Frame-buffer geometry (row-major, index = GRID_WIDTH * row + column)
   localparam int GRID_WIDTH  = 16;
   localparam int GRID_HEIGHT = 16;

   // Radius limit and per-circle result guard
   localparam int MAX_RADIUS = 63;
   localparam int MAX_POINTS = 48;

   // Decision-value constants of the midpoint loop
   localparam int D_INIT      = 3;
   localparam int D_STEP_DIAG = 10;
   localparam int D_STEP_AXIS = 6;

   // Field and internal widths
   localparam int COORD_W = 8;   // unsigned coordinate fields
   localparam int COLOR_W = 24;
   localparam int INDEX_W = 8;
   localparam int RAD_W   = 6;   // saturated radius, also holds x
   localparam int Y_W     = 8;   // signed y, reaches -1
   localparam int D_W     = 12;  // signed decision value
   localparam int CNT_W   = 6;   // points emitted so far
   localparam int PIX_W   = 10;  // signed mirrored pixel coordinate
   localparam int PROD_W  = 17;  // full-width buffer index before truncation

   typedef logic signed [PIX_W-1:0] pix_type;

   typedef struct packed {
      logic [INDEX_W-1:0] index;
      logic               on_grid;
   } plot_type;

   // Controller to datapath
   typedef struct packed {
      logic load;   // take a new circle
      logic step;   // emit current point and advance the loop
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic last;   // current point is the final one of the circle
   } status_type;

   // One registered result transaction
   typedef struct packed {
      logic [INDEX_W-1:0] index_a;
      logic [INDEX_W-1:0] index_b;
      logic [INDEX_W-1:0] index_c;
      logic [INDEX_W-1:0] index_d;
      logic [INDEX_W-1:0] index_e;
      logic [INDEX_W-1:0] index_f;
      logic [INDEX_W-1:0] index_g;
      logic [INDEX_W-1:0] index_h;
      logic [7:0]         inside_mask;
      logic [COLOR_W-1:0] pixel_color;
      logic               last_point;
   } rsp_data_type;

   // Map one pixel to its buffer index; pixels off the grid give index 0
   function automatic plot_type plot_point(input pix_type px, input pix_type py);
      logic [PROD_W-1:0] wide;
      plot_type          p;
      wide = PROD_W'(GRID_WIDTH) * PROD_W'(py[PIX_W-2:0]) + PROD_W'(px[PIX_W-2:0]);
      p.on_grid = !px[PIX_W-1] && !py[PIX_W-1]
                  && ({1'b0, px[PIX_W-2:0]} < PIX_W'(GRID_WIDTH))
                  && ({1'b0, py[PIX_W-2:0]} < PIX_W'(GRID_HEIGHT));
      p.index   = p.on_grid ? wide[INDEX_W-1:0] : '0;
      return p;
   endfunction

endpackage

// ===== rtl/bcircle_ifs.sv =====
// Valid/ready channel interfaces for circle requests and point responses.
// Depends on bcircle_pkg for field widths.
interface bcircle_req_if;
   logic                               valid;
   logic                               ready;
   logic [bcircle_pkg::COORD_W-1:0]    center_x;
   logic [bcircle_pkg::COORD_W-1:0]    center_y;
   logic [bcircle_pkg::COORD_W-1:0]    radius;
   logic [bcircle_pkg::COLOR_W-1:0]    paint_color;

   modport source (output valid, center_x, center_y, radius, paint_color, input ready);
   modport sink   (input valid, center_x, center_y, radius, paint_color, output ready);
endinterface

interface bcircle_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [bcircle_pkg::INDEX_W-1:0]    index_a;
   logic [bcircle_pkg::INDEX_W-1:0]    index_b;
   logic [bcircle_pkg::INDEX_W-1:0]    index_c;
   logic [bcircle_pkg::INDEX_W-1:0]    index_d;
   logic [bcircle_pkg::INDEX_W-1:0]    index_e;
   logic [bcircle_pkg::INDEX_W-1:0]    index_f;
   logic [bcircle_pkg::INDEX_W-1:0]    index_g;
   logic [bcircle_pkg::INDEX_W-1:0]    index_h;
   logic [7:0]                         inside_mask;
   logic [bcircle_pkg::COLOR_W-1:0]    pixel_color;
   logic                               last_point;

   modport source (output valid, index_a, index_b, index_c, index_d, index_e, index_f,
                   index_g, index_h, inside_mask, pixel_color, last_point, input ready);
   modport sink   (input valid, index_a, index_b, index_c, index_d, index_e, index_f,
                   index_g, index_h, inside_mask, pixel_color, last_point, output ready);
endinterface

// ===== rtl/bcircle_ctrl.sv =====
// Control state machine of the circle point generator: handshakes and loop sequencing.
// Depends on bcircle_pkg (command and status types).
module bcircle_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  bcircle_pkg::status_type status,
   output bcircle_pkg::cmd_type    cmd
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_RUN  = 2'b10
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // Accept a new circle only when no point remains to be generated
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // Emit a point whenever the output register is free or being drained
   always_comb begin
      cmd.load = req_valid && req_ready;
      cmd.step = (state_ff == ST_RUN) && (!rsp_valid_ff || rsp_ready);
   end

   // Advance state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (cmd.load) state_in = ST_RUN;
         ST_RUN:  if (cmd.step && status.last) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // Hold the response until taken, set it on each emitted point
   assign rsp_valid_in = cmd.step || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_load_starts_run: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> state_ff == ST_RUN)
      else $error("accepted circle did not start the point loop");

   a_last_ends_run: assert property (@(posedge clock) disable iff (reset)
      cmd.step && status.last |=> state_ff == ST_IDLE)
      else $error("loop kept running after the last point");

   a_step_slot_free: assert property (@(posedge clock) disable iff (reset)
      cmd.step |-> (!rsp_valid_ff || rsp_ready))
      else $error("point emitted over an untaken response");

   a_valid_from_step: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(cmd.step))
      else $error("response appeared without an emitted point");

endmodule

// ===== rtl/bcircle_dp.sv =====
// Datapath of the circle point generator: loop registers, eight-way mirroring and
// the registered response. Depends on bcircle_pkg.
module bcircle_dp (
   input  logic                                 clock,
   input  bcircle_pkg::cmd_type                 cmd,
   output bcircle_pkg::status_type              status,
   input  logic [bcircle_pkg::COORD_W-1:0]      center_x,
   input  logic [bcircle_pkg::COORD_W-1:0]      center_y,
   input  logic [bcircle_pkg::COORD_W-1:0]      radius,
   input  logic [bcircle_pkg::COLOR_W-1:0]      paint_color,
   output bcircle_pkg::rsp_data_type            rsp_data
);

   localparam int RAD_W = bcircle_pkg::RAD_W;
   localparam int Y_W   = bcircle_pkg::Y_W;
   localparam int D_W   = bcircle_pkg::D_W;
   localparam int CNT_W = bcircle_pkg::CNT_W;
   localparam int PIX_W = bcircle_pkg::PIX_W;

   logic [bcircle_pkg::COORD_W-1:0] cx_ff, cx_in, cy_ff, cy_in;
   logic [bcircle_pkg::COLOR_W-1:0] color_ff, color_in;
   logic [RAD_W-1:0]                x_ff, x_in;
   logic signed [Y_W-1:0]           y_ff, y_in;
   logic signed [D_W-1:0]           d_ff, d_in;
   logic [CNT_W-1:0]                cnt_ff, cnt_in;
   bcircle_pkg::rsp_data_type       rsp_ff, rsp_in;

   logic [RAD_W-1:0]                rad_sat;
   logic [RAD_W-1:0]                x_next;
   logic signed [Y_W-1:0]           y_next;
   logic signed [D_W-1:0]           x_next_d, y_next_d;
   logic                            more;
   bcircle_pkg::pix_type            cxs, cys, xs, ys;
   bcircle_pkg::plot_type           pa, pb, pc, pd, pe, pf, pg, ph;

   // Saturate the radius
   assign rad_sat = (radius > bcircle_pkg::COORD_W'(bcircle_pkg::MAX_RADIUS))
                    ? RAD_W'(bcircle_pkg::MAX_RADIUS) : radius[RAD_W-1:0];

   // Continue while y >= x and the result guard is not reached
   assign more = (y_ff >= $signed({{(Y_W-RAD_W){1'b0}}, x_ff}))
                 && (cnt_ff < CNT_W'(bcircle_pkg::MAX_POINTS - 1));
   assign status.last = !more;

   // Decision-loop step
   always_comb begin
      x_next   = x_ff + RAD_W'(1);
      y_next   = (d_ff > 0) ? y_ff - Y_W'(1) : y_ff;
      x_next_d = $signed({{(D_W-RAD_W){1'b0}}, x_next});
      y_next_d = D_W'(y_next);
   end

   // Mirror the current point into eight octants
   always_comb begin
      cxs = $signed({{(PIX_W-bcircle_pkg::COORD_W){1'b0}}, cx_ff});
      cys = $signed({{(PIX_W-bcircle_pkg::COORD_W){1'b0}}, cy_ff});
      xs  = $signed({{(PIX_W-RAD_W){1'b0}}, x_ff});
      ys  = PIX_W'(y_ff);
      pa  = bcircle_pkg::plot_point(cxs + xs, cys + ys);
      pb  = bcircle_pkg::plot_point(cxs - xs, cys + ys);
      pc  = bcircle_pkg::plot_point(cxs + xs, cys - ys);
      pd  = bcircle_pkg::plot_point(cxs - xs, cys - ys);
      pe  = bcircle_pkg::plot_point(cxs + ys, cys + xs);
      pf  = bcircle_pkg::plot_point(cxs - ys, cys + xs);
      pg  = bcircle_pkg::plot_point(cxs + ys, cys - xs);
      ph  = bcircle_pkg::plot_point(cxs - ys, cys - xs);
   end

   // Next values of loop registers and response
   always_comb begin
      cx_in    = cx_ff;
      cy_in    = cy_ff;
      color_in = color_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      d_in     = d_ff;
      cnt_in   = cnt_ff;
      rsp_in   = rsp_ff;
      if (cmd.load) begin
         cx_in    = center_x;
         cy_in    = center_y;
         color_in = paint_color;
         x_in     = '0;
         y_in     = $signed({{(Y_W-RAD_W){1'b0}}, rad_sat});
         d_in     = D_W'(bcircle_pkg::D_INIT)
                    - $signed({{(D_W-RAD_W-1){1'b0}}, rad_sat, 1'b0});
         cnt_in   = '0;
      end else if (cmd.step) begin
         rsp_in.index_a     = pa.index;
         rsp_in.index_b     = pb.index;
         rsp_in.index_c     = pc.index;
         rsp_in.index_d     = pd.index;
         rsp_in.index_e     = pe.index;
         rsp_in.index_f     = pf.index;
         rsp_in.index_g     = pg.index;
         rsp_in.index_h     = ph.index;
         rsp_in.inside_mask = {ph.on_grid, pg.on_grid, pf.on_grid, pe.on_grid,
                               pd.on_grid, pc.on_grid, pb.on_grid, pa.on_grid};
         rsp_in.pixel_color = color_ff;
         rsp_in.last_point  = !more;
         x_in   = x_next;
         y_in   = y_next;
         d_in   = (d_ff > 0)
                  ? d_ff + ((x_next_d - y_next_d) <<< 2) + D_W'(bcircle_pkg::D_STEP_DIAG)
                  : d_ff + (x_next_d <<< 2) + D_W'(bcircle_pkg::D_STEP_AXIS);
         cnt_in = cnt_ff + CNT_W'(1);
      end
   end

   // Payload registers need no reset
   always_ff @(posedge clock) begin
      cx_ff    <= cx_in;
      cy_ff    <= cy_in;
      color_ff <= color_in;
      x_ff     <= x_in;
      y_ff     <= y_in;
      d_ff     <= d_in;
      cnt_ff   <= cnt_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_data = rsp_ff;

endmodule

// ===== rtl/bresenham_circle_pixel_generator.sv =====
// Top level of the midpoint circle point generator: wires controller and datapath
// to the request and response channels. Depends on bcircle_pkg, bcircle_ifs,
// bcircle_ctrl and bcircle_dp.
//
// Each request transaction describes one circle (center, radius saturated to 63, color)
// and yields one response transaction per octant point, each carrying the eight mirrored
// row-major buffer indices, an inside mask, the color and last_point on the final one.
// A circle of radius r gives about 0.71*r + 2 points (at most 48). The request is loaded
// into the loop registers, then the decision loop register set produces one point per cycle
// while the response register is free or being drained. The next request is taken as soon
// as the last point has been loaded into the response register.
module bresenham_circle_pixel_generator (
   input logic          clock,
   input logic          reset,
   bcircle_req_if.sink   req_chan,
   bcircle_rsp_if.source rsp_chan
);

   bcircle_pkg::cmd_type      cmd;
   bcircle_pkg::status_type   status;
   bcircle_pkg::rsp_data_type rsp_data;

   bcircle_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   bcircle_dp u_dp (
      .clock       (clock),
      .cmd         (cmd),
      .status      (status),
      .center_x    (req_chan.center_x),
      .center_y    (req_chan.center_y),
      .radius      (req_chan.radius),
      .paint_color (req_chan.paint_color),
      .rsp_data    (rsp_data)
   );

   // Drive response payload
   assign rsp_chan.index_a     = rsp_data.index_a;
   assign rsp_chan.index_b     = rsp_data.index_b;
   assign rsp_chan.index_c     = rsp_data.index_c;
   assign rsp_chan.index_d     = rsp_data.index_d;
   assign rsp_chan.index_e     = rsp_data.index_e;
   assign rsp_chan.index_f     = rsp_data.index_f;
   assign rsp_chan.index_g     = rsp_data.index_g;
   assign rsp_chan.index_h     = rsp_data.index_h;
   assign rsp_chan.inside_mask = rsp_data.inside_mask;
   assign rsp_chan.pixel_color = rsp_data.pixel_color;
   assign rsp_chan.last_point  = rsp_data.last_point;

endmodule

// ===== bench/circle_point_checker.sv =====
// Point checker for the midpoint circle generator: watches both channels, predicts
// every octant point of each accepted circle and compares the response transactions.
// Depends on bcircle_pkg and the channel interfaces in rtl/bcircle_ifs.sv.
module circle_point_checker (
   input  logic   clock,
   input  logic   reset,
   bcircle_req_if req_mon,
   bcircle_rsp_if rsp_mon,
   output int     fail_count,
   output int     points_due
);
   timeunit 1ns;
   timeprecision 1ps;

   // Points still owed by the block, oldest first
   bcircle_pkg::rsp_data_type expected_points[$];

   initial begin
      fail_count = 0;
      points_due = 0;
   end

   // Build one response from the current loop position: eight mirrored pixels,
   // each mapped to its row-major index or to zero when it falls off the grid
   function automatic bcircle_pkg::rsp_data_type octant_point(
         input int cx, input int cy, input int x, input int y,
         input logic [bcircle_pkg::COLOR_W-1:0] col);
      int                        px[8];
      int                        py[8];
      logic [7:0]                idx[8];
      logic [7:0]                mask;
      bcircle_pkg::rsp_data_type pt;
      px = '{cx + x, cx - x, cx + x, cx - x, cx + y, cx - y, cx + y, cx - y};
      py = '{cy + y, cy + y, cy - y, cy - y, cy + x, cy + x, cy - x, cy - x};
      mask = '0;
      for (int k = 0; k < 8; k++) begin
         if (px[k] >= 0 && py[k] >= 0 && px[k] < bcircle_pkg::GRID_WIDTH
             && py[k] < bcircle_pkg::GRID_HEIGHT) begin
            idx[k]  = 8'(bcircle_pkg::GRID_WIDTH * py[k] + px[k]);
            mask[k] = 1'b1;
         end else begin
            idx[k] = '0;
         end
      end
      pt.index_a     = idx[0];
      pt.index_b     = idx[1];
      pt.index_c     = idx[2];
      pt.index_d     = idx[3];
      pt.index_e     = idx[4];
      pt.index_f     = idx[5];
      pt.index_g     = idx[6];
      pt.index_h     = idx[7];
      pt.inside_mask = mask;
      pt.pixel_color = col;
      pt.last_point  = 1'b0;
      return pt;
   endfunction

   // Run the decision loop for one circle and queue every point it draws
   task automatic trace_circle(input logic [bcircle_pkg::COORD_W-1:0] cx_in,
                               input logic [bcircle_pkg::COORD_W-1:0] cy_in,
                               input logic [bcircle_pkg::COORD_W-1:0] rad_in,
                               input logic [bcircle_pkg::COLOR_W-1:0] col);
      int                        cx;
      int                        cy;
      int                        rad;
      int                        x;
      int                        y;
      int                        dec;
      int                        count;
      bcircle_pkg::rsp_data_type pt;
      cx  = int'(cx_in);
      cy  = int'(cy_in);
      rad = (int'(rad_in) > bcircle_pkg::MAX_RADIUS) ? bcircle_pkg::MAX_RADIUS : int'(rad_in);
      x   = 0;
      y   = rad;
      dec = bcircle_pkg::D_INIT - 2 * rad;
      pt  = octant_point(cx, cy, x, y, col);
      count = 1;
      while (y >= x && count < bcircle_pkg::MAX_POINTS) begin
         expected_points.push_back(pt);
         x++;
         // step diagonally when the decision value is positive, else along the axis
         if (dec > 0) begin
            y--;
            dec = dec + 4 * (x - y) + bcircle_pkg::D_STEP_DIAG;
         end else begin
            dec = dec + 4 * x + bcircle_pkg::D_STEP_AXIS;
         end
         pt = octant_point(cx, cy, x, y, col);
         count++;
      end
      pt.last_point = 1'b1;
      expected_points.push_back(pt);
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
         fail_count++;
      end
   endtask

   // Predict on each request transaction, compare on each response transaction
   always @(posedge clock) begin
      bcircle_pkg::rsp_data_type want;
      if (!reset) begin
         if (req_mon.valid && req_mon.ready)
            trace_circle(req_mon.center_x, req_mon.center_y, req_mon.radius,
                         req_mon.paint_color);
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_points.size() == 0) begin
               $error("point response with none outstanding, index_a 0x%0h", rsp_mon.index_a);
               fail_count++;
            end else begin
               want = expected_points.pop_front();
               check_field("index_a", 32'(want.index_a), 32'(rsp_mon.index_a));
               check_field("index_b", 32'(want.index_b), 32'(rsp_mon.index_b));
               check_field("index_c", 32'(want.index_c), 32'(rsp_mon.index_c));
               check_field("index_d", 32'(want.index_d), 32'(rsp_mon.index_d));
               check_field("index_e", 32'(want.index_e), 32'(rsp_mon.index_e));
               check_field("index_f", 32'(want.index_f), 32'(rsp_mon.index_f));
               check_field("index_g", 32'(want.index_g), 32'(rsp_mon.index_g));
               check_field("index_h", 32'(want.index_h), 32'(rsp_mon.index_h));
               check_field("inside_mask", 32'(want.inside_mask), 32'(rsp_mon.inside_mask));
               check_field("pixel_color", 32'(want.pixel_color), 32'(rsp_mon.pixel_color));
               check_field("last_point", 32'(want.last_point), 32'(rsp_mon.last_point));
            end
         end
         points_due = expected_points.size();
      end
   end

endmodule

// ===== bench/tb_top.sv =====
// Top of the circle generator bench: clock, reset, circle stimulus and response drain.
// Depends on bcircle_pkg, rtl/bcircle_ifs.sv, the generator RTL and circle_point_checker.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT    = 1_000_000;
   localparam int RANDOM_CIRCLES = 162;
   localparam int HOLD_AT_POINT  = 150;
   localparam int HOLD_CYCLES    = 400;
   localparam int DRAIN_CYCLES   = 64;

   logic clock;
   logic reset;
   int   fail_count;
   int   points_due;
   int   cycles = 0;
   int   circles_sent = 0;
   int   points_taken = 0;
   bit   send_quiet = 1'b0;
   bit   take_quiet = 1'b0;

   bcircle_req_if req_chan();
   bcircle_rsp_if rsp_chan();

   bresenham_circle_pixel_generator dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   circle_point_checker point_check (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_chan),
      .rsp_mon    (rsp_chan),
      .fail_count (fail_count),
      .points_due (points_due)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // Offer one circle after a random gap and hold it until the transaction completes;
   // called at a falling edge and returns at one
   task automatic send_circle(input logic [bcircle_pkg::COORD_W-1:0] cx,
                              input logic [bcircle_pkg::COORD_W-1:0] cy,
                              input logic [bcircle_pkg::COORD_W-1:0] rad,
                              input logic [bcircle_pkg::COLOR_W-1:0] col);
      int gap;
      if (circles_sent % 20 == 0)
         send_quiet = ($urandom_range(0, 3) == 0);
      gap = send_quiet ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
         req_chan.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.center_x    = cx;
      req_chan.center_y    = cy;
      req_chan.radius      = rad;
      req_chan.paint_color = col;
      req_chan.valid       = 1'b1;
      do @(posedge clock); while (!req_chan.ready);
      circles_sent++;
      @(negedge clock);
   endtask

   // Mostly near the grid so that points land inside, sometimes anywhere
   function automatic logic [bcircle_pkg::COORD_W-1:0] pick_coord();
      return ($urandom_range(0, 3) == 0) ? bcircle_pkg::COORD_W'($urandom_range(0, 255))
                                         : bcircle_pkg::COORD_W'($urandom_range(0, 23));
   endfunction

   // Response side: random stall per transaction, quiet stretches, one long hold-off
   initial begin
      int gap;
      rsp_chan.ready = 1'b0;
      do @(negedge clock); while (reset !== 1'b0);
      forever begin
         if (points_taken % 32 == 0)
            take_quiet = ($urandom_range(0, 3) == 0);
         gap = take_quiet ? 0 : $urandom_range(0, 16);
         if (points_taken == HOLD_AT_POINT)
            gap = HOLD_CYCLES;
         if (gap > 0) begin
            rsp_chan.ready = 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_chan.ready = 1'b1;
         do @(posedge clock); while (!rsp_chan.valid);
         points_taken++;
         @(negedge clock);
      end
   end

   // Reset, directed circles, random circles, drain and verdict
   initial begin
      logic [bcircle_pkg::COORD_W-1:0] rad;
      int                              sel;
      reset                = 1'b1;
      req_chan.valid       = 1'b0;
      req_chan.center_x    = '0;
      req_chan.center_y    = '0;
      req_chan.radius      = '0;
      req_chan.paint_color = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // tiny radii, corners and edges, saturated radius, far off-grid centers
      send_circle(8'd0,   8'd0,   8'd0,   24'h000000);
      send_circle(8'd8,   8'd8,   8'd0,   24'hFFFFFF);
      send_circle(8'd8,   8'd8,   8'd1,   24'hAAAAAA);
      send_circle(8'd8,   8'd8,   8'd2,   24'h555555);
      send_circle(8'd8,   8'd8,   8'd3,   24'h123456);
      send_circle(8'd7,   8'd7,   8'd7,   24'hFEDCBA);
      send_circle(8'd0,   8'd0,   8'd5,   24'h0F0F0F);
      send_circle(8'd15,  8'd15,  8'd5,   24'hF0F0F0);
      send_circle(8'd0,   8'd15,  8'd9,   24'h00FF00);
      send_circle(8'd15,  8'd0,   8'd9,   24'hFF0000);
      send_circle(8'd255, 8'd255, 8'd255, 24'hFFFFFF);
      send_circle(8'd8,   8'd8,   8'd63,  24'h0000FF);
      send_circle(8'd8,   8'd8,   8'd64,  24'h800001);
      send_circle(8'd128, 8'd128, 8'd200, 24'h800000);
      send_circle(8'd3,   8'd12,  8'd4,   24'h7FFFFF);
      send_circle(8'd20,  8'd20,  8'd6,   24'h010101);
      send_circle(8'd8,   8'd250, 8'd10,  24'hC3C3C3);
      send_circle(8'd250, 8'd8,   8'd10,  24'h3C3C3C);

      // random circles, mostly small radii around the grid
      repeat (RANDOM_CIRCLES) begin
         sel = $urandom_range(0, 19);
         if (sel < 12)
            rad = bcircle_pkg::COORD_W'($urandom_range(0, 15));
         else if (sel < 17)
            rad = bcircle_pkg::COORD_W'($urandom_range(16, 63));
         else
            rad = bcircle_pkg::COORD_W'($urandom_range(64, 255));
         send_circle(pick_coord(), pick_coord(), rad, bcircle_pkg::COLOR_W'($urandom));
      end
      req_chan.valid = 1'b0;

      // drain outstanding points, then give stray responses time to show up
      while (points_due != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (fail_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/bcircle_pkg.sv
rtl/bcircle_ifs.sv
rtl/bcircle_ctrl.sv
rtl/bcircle_dp.sv
rtl/bresenham_circle_pixel_generator.sv
bench/circle_point_checker.sv
bench/tb_top.sv
